/* hw/rtl/rsnp_pkg.sv */
// shared types, constants and codes for the ray-sphere nearest pick unit
`default_nettype none

package rsnp_pkg;

   // sizing
   localparam int DEFAULT_MAX_BODIES = 1024;
   localparam int CNT_W   = 11;     // body_count register
   localparam int IDX_W   = 10;     // slot index field
   localparam int OPS_W   = 67;     // signed multiplier operand
   localparam int MAG_W   = 66;     // operand magnitude
   localparam int PROD_W  = 132;    // product magnitude
   localparam int A_W     = 64;     // dir.dir
   localparam int HB_W    = 66;     // oc.dir
   localparam int C_W     = 67;     // oc.oc - r^2
   localparam int DISC_W  = 132;    // hb^2 - a*c
   localparam int ROOT_W  = 66;     // floor sqrt of disc
   localparam int SREM_W  = 67;     // square root remainder
   localparam int NUM_W   = 68;     // -hb - root
   localparam int QUO_W   = 84;     // hit distance
   localparam int DREM_W  = 64;     // divider remainder
   localparam int STEP_W  = 7;
   localparam int SQRT_STEPS = DISC_W / 2;
   localparam int DIV_STEPS  = QUO_W;

   // item actions
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // register index
   localparam logic CSR_BODY_COUNT = 1'b0;

   // datapath operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_QUERY = 3'd1;
   localparam logic [2:0] OP_LOAD  = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_SQRT  = 3'd4;
   localparam logic [2:0] OP_NUM   = 3'd5;
   localparam logic [2:0] OP_DIV   = 3'd6;
   localparam logic [2:0] OP_PICK  = 3'd7;

   // multiplier operand pairs
   localparam logic [3:0] SRC_DXDX = 4'd0;
   localparam logic [3:0] SRC_DYDY = 4'd1;
   localparam logic [3:0] SRC_DZDZ = 4'd2;
   localparam logic [3:0] SRC_OXDX = 4'd3;
   localparam logic [3:0] SRC_OYDY = 4'd4;
   localparam logic [3:0] SRC_OZDZ = 4'd5;
   localparam logic [3:0] SRC_OXOX = 4'd6;
   localparam logic [3:0] SRC_OYOY = 4'd7;
   localparam logic [3:0] SRC_OZOZ = 4'd8;
   localparam logic [3:0] SRC_RR   = 4'd9;
   localparam logic [3:0] SRC_HBHB = 4'd10;
   localparam logic [3:0] SRC_AC   = 4'd11;

   // product destinations
   localparam logic [1:0] DST_A    = 2'd0;
   localparam logic [1:0] DST_HB   = 2'd1;
   localparam logic [1:0] DST_C    = 2'd2;
   localparam logic [1:0] DST_DISC = 2'd3;

   typedef struct packed {
      logic               action;
      logic [9:0]         index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [30:0]        radius;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic       hit_found;
      logic [9:0] hit_index;
   } rsp_type;

   typedef struct packed {
      logic [30:0]        radius;
      logic signed [31:0] cz;
      logic signed [31:0] cy;
      logic signed [31:0] cx;
   } sphere_type;

   typedef struct packed {
      logic       go;
      logic [2:0] op;
      logic [3:0] src;
      logic [1:0] dst;
      logic       sub;
      logic       clr;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic done;
      logic a_zero;
      logic hb_neg;
      logic c_pos;
      logic disc_neg;
      logic num_pos;
      logic t_nz;
      logic t_better;
   } stat_type;

endpackage

`default_nettype wire

/* hw/rtl/ray_sphere_nearest_pick_unit.sv */
// top level: sphere table, register port, controller and datapath
//
// Usage. A beat on the request channel is taken when start is high and busy
// is low. A write beat (action 0) stores one sphere at slot index and gives
// no result; slots at or past MAX_BODIES are ignored. A query beat (action 1)
// scans slots 0 .. body_count-1 (clamped to MAX_BODIES; none if the direction
// is zero) and gives exactly one result beat, rsp_valid high for one cycle
// with hit_found and hit_index; the receiver cannot hold it off. busy is high
// from the cycle after the query beat up to and including the result cycle.
// A query first forms dir.dir from three serial products, then for each
// sphere runs up to nine products, a square root and a divide. A product
// takes longer the more bits the magnitude of its second operand has (up to
// 66 bits); spheres behind the origin leave after the oc.dir products and
// spheres enclosing it after the oc.oc - r^2 products. One query is worked
// on at a time; a write beat does not make busy high.
// body_count sits at byte address 0 of the register port and resets to 0.
// Reset clears the controller and the register; the sphere table is not
// cleared and a slot must be written before a query reads it.
`default_nettype none

module ray_sphere_nearest_pick_unit #(
   parameter int MAX_BODIES = rsnp_pkg::DEFAULT_MAX_BODIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              start,
   output logic                   busy,
   input  wire rsnp_pkg::req_type req_data,
   // result channel
   output logic                   rsp_valid,
   output rsnp_pkg::rsp_type      rsp_data,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int AW = MAX_BODIES > 1 ? $clog2(MAX_BODIES) : 1;

   logic [rsnp_pkg::CNT_W-1:0] body_count_ff;
   rsnp_pkg::cmd_type          cmd;
   rsnp_pkg::stat_type         stat;
   rsnp_pkg::sphere_type       wsphere, rsphere;
   logic [AW-1:0]              scan_idx;
   logic                       ram_we;

   // register write and read back
   always_ff @(posedge clock) begin
      if (reset) begin
         body_count_ff <= '0;
      end else if (psel && penable && pwrite && paddr[2] == rsnp_pkg::CSR_BODY_COUNT) begin
         body_count_ff <= pwdata[rsnp_pkg::CNT_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == rsnp_pkg::CSR_BODY_COUNT) ? 32'(body_count_ff) : '0;

   // sphere write beat
   assign ram_we = start && !busy && req_data.action == rsnp_pkg::ACT_WRITE
                   && (32'(req_data.index) < 32'(MAX_BODIES));

   always_comb begin
      wsphere.cx     = req_data.x;
      wsphere.cy     = req_data.y;
      wsphere.cz     = req_data.z;
      wsphere.radius = req_data.radius;
   end

   rsnp_ram #(
      .WIDTH ($bits(rsnp_pkg::sphere_type)),
      .DEPTH (MAX_BODIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_data.index)),
      .wdata (wsphere),
      .raddr (scan_idx),
      .rdata (rsphere)
   );

   rsnp_ctrl #(
      .MAX_BODIES (MAX_BODIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .body_count (body_count_ff),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd),
      .scan_idx   (scan_idx),
      .rsp_valid  (rsp_valid)
   );

   rsnp_datapath #(
      .MAX_BODIES (MAX_BODIES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .scan_idx (scan_idx),
      .sphere   (rsphere),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/rsnp_ram.sv */
// generic single-write, single-read memory with registered read data
`default_nettype none

module rsnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/rsnp_datapath.sv */
// datapath: query registers, bit-serial multiplier, square root, divider, best pick
`default_nettype none

module rsnp_datapath #(
   parameter int MAX_BODIES = rsnp_pkg::DEFAULT_MAX_BODIES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rsnp_pkg::req_type    req_data,
   input  wire rsnp_pkg::cmd_type    cmd,
   input  wire logic [(MAX_BODIES > 1 ? $clog2(MAX_BODIES) : 1)-1:0] scan_idx,
   input  wire rsnp_pkg::sphere_type sphere,
   output rsnp_pkg::stat_type        stat,
   output rsnp_pkg::rsp_type         rsp_data
);

   // query registers
   logic signed [31:0] ox0_ff, oy0_ff, oz0_ff, dx_ff, dy_ff, dz_ff;
   logic signed [32:0] ox_ff, oy_ff, oz_ff;
   logic [30:0]        r_ff;

   // quadratic terms
   logic [rsnp_pkg::A_W-1:0]           a_ff;
   logic signed [rsnp_pkg::HB_W-1:0]   hb_ff;
   logic signed [rsnp_pkg::C_W-1:0]    c_ff;
   logic signed [rsnp_pkg::DISC_W-1:0] disc_ff;
   logic signed [rsnp_pkg::NUM_W-1:0]  num_ff;

   // engine state
   logic                               run_ff;
   logic [2:0]                         mode_ff;
   logic [rsnp_pkg::STEP_W-1:0]        cnt_ff;
   logic [rsnp_pkg::PROD_W-1:0]        ma_ff, acc_ff;
   logic [rsnp_pkg::MAG_W-1:0]         mb_ff;
   logic                               neg_ff;
   logic [rsnp_pkg::DISC_W-1:0]        sn_ff;
   logic [rsnp_pkg::ROOT_W-1:0]        root_ff;
   logic [rsnp_pkg::SREM_W-1:0]        srem_ff;
   logic [rsnp_pkg::QUO_W-1:0]         qd_ff;
   logic [rsnp_pkg::DREM_W-1:0]        drem_ff;

   // best hit so far
   logic                               found_ff;
   logic [rsnp_pkg::QUO_W-1:0]         best_t_ff;
   logic [rsnp_pkg::IDX_W-1:0]         best_i_ff;

   logic signed [rsnp_pkg::OPS_W-1:0]  opa, opb;
   logic [rsnp_pkg::MAG_W-1:0]         maga, magb;
   logic [rsnp_pkg::PROD_W-1:0]        prod_s, base, dsum;
   logic [rsnp_pkg::SREM_W+1:0]        s_remsh, s_trial;
   logic                               s_ge;
   logic [rsnp_pkg::DREM_W:0]          d_remsh;
   logic                               d_ge;
   logic                               mul_end, sqrt_end, div_end;

   // multiplier operand pair
   always_comb begin
      case (cmd.src)
         rsnp_pkg::SRC_DXDX: begin opa = rsnp_pkg::OPS_W'(dx_ff); opb = rsnp_pkg::OPS_W'(dx_ff); end
         rsnp_pkg::SRC_DYDY: begin opa = rsnp_pkg::OPS_W'(dy_ff); opb = rsnp_pkg::OPS_W'(dy_ff); end
         rsnp_pkg::SRC_DZDZ: begin opa = rsnp_pkg::OPS_W'(dz_ff); opb = rsnp_pkg::OPS_W'(dz_ff); end
         rsnp_pkg::SRC_OXDX: begin opa = rsnp_pkg::OPS_W'(ox_ff); opb = rsnp_pkg::OPS_W'(dx_ff); end
         rsnp_pkg::SRC_OYDY: begin opa = rsnp_pkg::OPS_W'(oy_ff); opb = rsnp_pkg::OPS_W'(dy_ff); end
         rsnp_pkg::SRC_OZDZ: begin opa = rsnp_pkg::OPS_W'(oz_ff); opb = rsnp_pkg::OPS_W'(dz_ff); end
         rsnp_pkg::SRC_OXOX: begin opa = rsnp_pkg::OPS_W'(ox_ff); opb = rsnp_pkg::OPS_W'(ox_ff); end
         rsnp_pkg::SRC_OYOY: begin opa = rsnp_pkg::OPS_W'(oy_ff); opb = rsnp_pkg::OPS_W'(oy_ff); end
         rsnp_pkg::SRC_OZOZ: begin opa = rsnp_pkg::OPS_W'(oz_ff); opb = rsnp_pkg::OPS_W'(oz_ff); end
         rsnp_pkg::SRC_RR: begin
            opa = $signed({36'd0, r_ff});
            opb = $signed({36'd0, r_ff});
         end
         rsnp_pkg::SRC_HBHB: begin opa = rsnp_pkg::OPS_W'(hb_ff); opb = rsnp_pkg::OPS_W'(hb_ff); end
         rsnp_pkg::SRC_AC: begin
            opa = $signed({3'd0, a_ff});
            opb = rsnp_pkg::OPS_W'(c_ff);
         end
         default: begin opa = '0; opb = '0; end
      endcase
      maga = opa[rsnp_pkg::OPS_W-1] ? rsnp_pkg::MAG_W'(-opa) : rsnp_pkg::MAG_W'(opa);
      magb = opb[rsnp_pkg::OPS_W-1] ? rsnp_pkg::MAG_W'(-opb) : rsnp_pkg::MAG_W'(opb);
   end

   // signed product folded into its destination
   always_comb begin
      prod_s = (neg_ff ^ cmd.sub) ? (~acc_ff + rsnp_pkg::PROD_W'(1)) : acc_ff;
      case (cmd.dst)
         rsnp_pkg::DST_A:    base = rsnp_pkg::PROD_W'(a_ff);
         rsnp_pkg::DST_HB:   base = rsnp_pkg::PROD_W'(hb_ff);
         rsnp_pkg::DST_C:    base = rsnp_pkg::PROD_W'(c_ff);
         rsnp_pkg::DST_DISC: base = rsnp_pkg::PROD_W'(disc_ff);
         default:            base = '0;
      endcase
      dsum = (cmd.clr ? '0 : base) + prod_s;
   end

   // one square root step and one divider step
   always_comb begin
      s_remsh = {srem_ff, sn_ff[rsnp_pkg::DISC_W-1 -: 2]};
      s_trial = {1'b0, root_ff, 2'b01};
      s_ge    = s_remsh >= s_trial;
      d_remsh = {drem_ff, qd_ff[rsnp_pkg::QUO_W-1]};
      d_ge    = d_remsh >= {1'b0, a_ff};
   end

   assign mul_end  = run_ff && (mode_ff == rsnp_pkg::OP_MUL) && (mb_ff == '0);
   assign sqrt_end = run_ff && (mode_ff == rsnp_pkg::OP_SQRT)
                     && (cnt_ff == rsnp_pkg::STEP_W'(rsnp_pkg::SQRT_STEPS - 1));
   assign div_end  = run_ff && (mode_ff == rsnp_pkg::OP_DIV)
                     && (cnt_ff == rsnp_pkg::STEP_W'(rsnp_pkg::DIV_STEPS - 1));

   // engine control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (cmd.go) begin
         run_ff <= 1'b1;
      end else if (mul_end || sqrt_end || div_end) begin
         run_ff <= 1'b0;
      end
   end

   // found flag
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.op == rsnp_pkg::OP_QUERY) begin
         found_ff <= 1'b0;
      end else if (cmd.op == rsnp_pkg::OP_PICK) begin
         found_ff <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // query beat
      if (cmd.op == rsnp_pkg::OP_QUERY) begin
         ox0_ff    <= req_data.x;
         oy0_ff    <= req_data.y;
         oz0_ff    <= req_data.z;
         dx_ff     <= req_data.dir_x;
         dy_ff     <= req_data.dir_y;
         dz_ff     <= req_data.dir_z;
         best_i_ff <= '0;
      end
      // sphere offsets from the table
      if (cmd.op == rsnp_pkg::OP_LOAD) begin
         ox_ff <= 33'(ox0_ff) - 33'(sphere.cx);
         oy_ff <= 33'(oy0_ff) - 33'(sphere.cy);
         oz_ff <= 33'(oz0_ff) - 33'(sphere.cz);
         r_ff  <= sphere.radius;
      end
      // engine start
      if (cmd.go) begin
         mode_ff <= cmd.op;
         cnt_ff  <= '0;
         ma_ff   <= rsnp_pkg::PROD_W'(maga);
         mb_ff   <= magb;
         acc_ff  <= '0;
         neg_ff  <= opa[rsnp_pkg::OPS_W-1] ^ opb[rsnp_pkg::OPS_W-1];
         sn_ff   <= disc_ff;
         root_ff <= '0;
         srem_ff <= '0;
         qd_ff   <= {num_ff, 16'd0};
         drem_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + rsnp_pkg::STEP_W'(1);
         case (mode_ff)
            rsnp_pkg::OP_MUL: begin
               if (mb_ff == '0) begin
                  case (cmd.dst)
                     rsnp_pkg::DST_A:    a_ff    <= rsnp_pkg::A_W'(dsum);
                     rsnp_pkg::DST_HB:   hb_ff   <= rsnp_pkg::HB_W'(dsum);
                     rsnp_pkg::DST_C:    c_ff    <= rsnp_pkg::C_W'(dsum);
                     rsnp_pkg::DST_DISC: disc_ff <= dsum;
                     default: ;
                  endcase
               end else begin
                  acc_ff <= acc_ff + (mb_ff[0] ? ma_ff : '0);
                  ma_ff  <= ma_ff << 1;
                  mb_ff  <= mb_ff >> 1;
               end
            end
            rsnp_pkg::OP_SQRT: begin
               sn_ff   <= sn_ff << 2;
               srem_ff <= s_ge ? rsnp_pkg::SREM_W'(s_remsh - s_trial)
                               : rsnp_pkg::SREM_W'(s_remsh);
               root_ff <= {root_ff[rsnp_pkg::ROOT_W-2:0], s_ge};
            end
            rsnp_pkg::OP_DIV: begin
               drem_ff <= d_ge ? rsnp_pkg::DREM_W'(d_remsh - {1'b0, a_ff})
                               : rsnp_pkg::DREM_W'(d_remsh);
               qd_ff   <= {qd_ff[rsnp_pkg::QUO_W-2:0], d_ge};
            end
            default: ;
         endcase
      end
      // near-root numerator
      if (cmd.op == rsnp_pkg::OP_NUM) begin
         num_ff <= -rsnp_pkg::NUM_W'(hb_ff) - rsnp_pkg::NUM_W'(root_ff);
      end
      // new best hit
      if (cmd.op == rsnp_pkg::OP_PICK) begin
         best_t_ff <= qd_ff;
         best_i_ff <= rsnp_pkg::IDX_W'(scan_idx);
      end
   end

   // status toward the controller
   always_comb begin
      stat.running  = run_ff;
      stat.done     = mul_end || sqrt_end || div_end;
      stat.a_zero   = a_ff == '0;
      stat.hb_neg   = hb_ff[rsnp_pkg::HB_W-1];
      stat.c_pos    = !c_ff[rsnp_pkg::C_W-1] && (c_ff != '0);
      stat.disc_neg = disc_ff[rsnp_pkg::DISC_W-1];
      stat.num_pos  = !num_ff[rsnp_pkg::NUM_W-1] && (num_ff != '0);
      stat.t_nz     = qd_ff != '0;
      stat.t_better = !found_ff || (qd_ff < best_t_ff);
   end

   assign rsp_data.hit_found = found_ff;
   assign rsp_data.hit_index = found_ff ? best_i_ff : '0;

   // checks
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !run_ff)
      else $error("engine started while running");
   a_pick_sets_found: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rsnp_pkg::OP_PICK) |=> found_ff && (best_t_ff != '0))
      else $error("pick stored a zero distance");
   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (stat.done && !cmd.go) |=> !run_ff)
      else $error("engine kept running after done");

endmodule

`default_nettype wire

/* hw/rtl/rsnp_ctrl.sv */
// controller: sequences query setup, per-sphere scan and result beat
`default_nettype none

module rsnp_ctrl #(
   parameter int MAX_BODIES = rsnp_pkg::DEFAULT_MAX_BODIES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        req_action,
   input  wire logic [rsnp_pkg::CNT_W-1:0]  body_count,
   input  wire rsnp_pkg::stat_type          stat,
   output logic                             busy,
   output rsnp_pkg::cmd_type                cmd,
   output logic [(MAX_BODIES > 1 ? $clog2(MAX_BODIES) : 1)-1:0] scan_idx,
   output logic                             rsp_valid
);

   localparam int AW = MAX_BODIES > 1 ? $clog2(MAX_BODIES) : 1;
   localparam int CW = $clog2(MAX_BODIES + 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_A0   = 5'd1;
   localparam logic [4:0] S_A1   = 5'd2;
   localparam logic [4:0] S_A2   = 5'd3;
   localparam logic [4:0] S_ACHK = 5'd4;
   localparam logic [4:0] S_RD   = 5'd5;
   localparam logic [4:0] S_LD   = 5'd6;
   localparam logic [4:0] S_H0   = 5'd7;
   localparam logic [4:0] S_H1   = 5'd8;
   localparam logic [4:0] S_H2   = 5'd9;
   localparam logic [4:0] S_HCHK = 5'd10;
   localparam logic [4:0] S_C0   = 5'd11;
   localparam logic [4:0] S_C1   = 5'd12;
   localparam logic [4:0] S_C2   = 5'd13;
   localparam logic [4:0] S_C3   = 5'd14;
   localparam logic [4:0] S_CCHK = 5'd15;
   localparam logic [4:0] S_D0   = 5'd16;
   localparam logic [4:0] S_D1   = 5'd17;
   localparam logic [4:0] S_DCHK = 5'd18;
   localparam logic [4:0] S_SQ   = 5'd19;
   localparam logic [4:0] S_NUM  = 5'd20;
   localparam logic [4:0] S_NCHK = 5'd21;
   localparam logic [4:0] S_DIV  = 5'd22;
   localparam logic [4:0] S_TCHK = 5'd23;
   localparam logic [4:0] S_NEXT = 5'd24;
   localparam logic [4:0] S_RSP  = 5'd25;

   logic [4:0]    state_ff, state_in;
   logic          issued_ff, issued_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in;
   logic          wait_op;

   // scan length clamped to the table depth
   assign n_in = (32'(body_count) > 32'(MAX_BODIES)) ? CW'(MAX_BODIES) : CW'(body_count);

   // command decode and next state
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      i_in      = i_ff;
      wait_op   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && req_action == rsnp_pkg::ACT_QUERY) begin
               cmd.op   = rsnp_pkg::OP_QUERY;
               state_in = S_A0;
            end
         end
         S_A0: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_DXDX; cmd.dst = rsnp_pkg::DST_A; cmd.clr = 1'b1;
            if (stat.done) state_in = S_A1;
         end
         S_A1: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_DYDY; cmd.dst = rsnp_pkg::DST_A;
            if (stat.done) state_in = S_A2;
         end
         S_A2: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_DZDZ; cmd.dst = rsnp_pkg::DST_A;
            if (stat.done) state_in = S_ACHK;
         end
         S_ACHK: begin
            i_in = '0;
            state_in = (stat.a_zero || n_ff == '0) ? S_RSP : S_RD;
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            cmd.op   = rsnp_pkg::OP_LOAD;
            state_in = S_H0;
         end
         S_H0: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OXDX; cmd.dst = rsnp_pkg::DST_HB; cmd.clr = 1'b1;
            if (stat.done) state_in = S_H1;
         end
         S_H1: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OYDY; cmd.dst = rsnp_pkg::DST_HB;
            if (stat.done) state_in = S_H2;
         end
         S_H2: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OZDZ; cmd.dst = rsnp_pkg::DST_HB;
            if (stat.done) state_in = S_HCHK;
         end
         S_HCHK: begin
            state_in = stat.hb_neg ? S_C0 : S_NEXT;
         end
         S_C0: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OXOX; cmd.dst = rsnp_pkg::DST_C; cmd.clr = 1'b1;
            if (stat.done) state_in = S_C1;
         end
         S_C1: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OYOY; cmd.dst = rsnp_pkg::DST_C;
            if (stat.done) state_in = S_C2;
         end
         S_C2: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_OZOZ; cmd.dst = rsnp_pkg::DST_C;
            if (stat.done) state_in = S_C3;
         end
         S_C3: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_RR; cmd.dst = rsnp_pkg::DST_C; cmd.sub = 1'b1;
            if (stat.done) state_in = S_CCHK;
         end
         S_CCHK: begin
            state_in = stat.c_pos ? S_D0 : S_NEXT;
         end
         S_D0: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_HBHB; cmd.dst = rsnp_pkg::DST_DISC; cmd.clr = 1'b1;
            if (stat.done) state_in = S_D1;
         end
         S_D1: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_MUL;
            cmd.src = rsnp_pkg::SRC_AC; cmd.dst = rsnp_pkg::DST_DISC; cmd.sub = 1'b1;
            if (stat.done) state_in = S_DCHK;
         end
         S_DCHK: begin
            state_in = stat.disc_neg ? S_NEXT : S_SQ;
         end
         S_SQ: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_SQRT;
            if (stat.done) state_in = S_NUM;
         end
         S_NUM: begin
            cmd.op   = rsnp_pkg::OP_NUM;
            state_in = S_NCHK;
         end
         S_NCHK: begin
            state_in = stat.num_pos ? S_DIV : S_NEXT;
         end
         S_DIV: begin
            wait_op = 1'b1; cmd.op = rsnp_pkg::OP_DIV;
            if (stat.done) state_in = S_TCHK;
         end
         S_TCHK: begin
            if (stat.t_nz && stat.t_better) cmd.op = rsnp_pkg::OP_PICK;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (i_ff + CW'(1) == n_ff) begin
               state_in = S_RSP;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_RSP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.go    = wait_op && !issued_ff;
      issued_in = stat.done ? 1'b0 : (issued_ff || cmd.go);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   // scan counters
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         n_ff <= n_in;
      end
      i_ff <= i_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RSP;
   assign scan_idx  = AW'(i_ff);

   // checks
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (i_ff < n_ff))
      else $error("scan index past body count");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == rsnp_pkg::ACT_QUERY) |=> busy)
      else $error("query beat did not start a scan");

endmodule

`default_nettype wire
